>>> rtl/core/inverse_bilinear_quad_map_core_assert.svh
// Assertion macros shared by the core RTL.
`ifndef INVERSE_BILINEAR_QUAD_MAP_CORE_ASSERT_SVH
`define INVERSE_BILINEAR_QUAD_MAP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define IBQM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ibqm assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define IBQM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ibqm assertion failed");

`endif

>>> rtl/core/ibqm_pkg.sv
`timescale 1ns / 1ps
package ibqm_pkg;

  localparam int Q_W   = 32;
  localparam int ACC_W = 42;
  localparam int FRAC  = 24;

  localparam logic signed [Q_W-1:0] Q_ONE  = 32'sd16777216;
  localparam logic signed [Q_W-1:0] Q_HALF = 32'sd8388608;
  localparam logic signed [Q_W-1:0] STEP_THR = 32'sd168;

  localparam logic [2:0] CFG_TL  = 3'd0;
  localparam logic [2:0] CFG_TR  = 3'd1;
  localparam logic [2:0] CFG_BR  = 3'd2;
  localparam logic [2:0] CFG_BL  = 3'd3;
  localparam logic [2:0] CFG_CAL = 3'd4;

  localparam logic [4:0] PC_DET  = 5'd23;
  localparam logic [4:0] PC_ERR  = 5'd24;
  localparam logic [4:0] PC_NUM  = 5'd29;
  localparam logic [4:0] PC_UPD  = 5'd30;
  localparam logic [4:0] PC_LAST = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_DETCHK, ST_DIVU, ST_DIVV, ST_CONV, ST_DONE
  } state_e;

  typedef enum logic [1:0] {ACC_LD, ACC_ADD, ACC_SUB} acc_e;

  typedef enum logic [5:0] {
    S_ONE, S_U, S_V, S_OMU, S_OMV, S_W00, S_W10, S_W11, S_W01,
    S_TLX, S_TRX, S_BRX, S_BLX, S_TLY, S_TRY, S_BRY, S_BLY,
    S_DXT, S_DXB, S_DXL, S_DXR, S_DYT, S_DYB, S_DYL, S_DYR,
    S_POSX, S_POSY, S_PX, S_PY, S_DXU, S_DXV, S_DYU, S_DYV,
    S_EX, S_EY, S_DU, S_DV
  } src_e;

  typedef enum logic [4:0] {
    D_NONE, D_U, D_V, D_OMU, D_OMV, D_W00, D_W10, D_W11, D_W01,
    D_POSX, D_POSY, D_DXU, D_DXV, D_DYU, D_DYV, D_DET, D_EX, D_EY, D_NU, D_NV
  } dst_e;

  typedef struct packed {
    logic mul;
    acc_e mode;
    src_e a;
    src_e b;
    dst_e d;
  } uop_t;

  function automatic uop_t uop_f(input logic [4:0] pc);
    uop_t r;
    case (pc)
      5'd0:  r = '{1'b0, ACC_LD,  S_ONE,  S_U,   D_OMU};
      5'd1:  r = '{1'b0, ACC_LD,  S_ONE,  S_V,   D_OMV};
      5'd2:  r = '{1'b1, ACC_LD,  S_OMU,  S_OMV, D_W00};
      5'd3:  r = '{1'b1, ACC_LD,  S_U,    S_OMV, D_W10};
      5'd4:  r = '{1'b1, ACC_LD,  S_U,    S_V,   D_W11};
      5'd5:  r = '{1'b1, ACC_LD,  S_OMU,  S_V,   D_W01};
      5'd6:  r = '{1'b1, ACC_LD,  S_W00,  S_TLX, D_NONE};
      5'd7:  r = '{1'b1, ACC_ADD, S_W10,  S_TRX, D_NONE};
      5'd8:  r = '{1'b1, ACC_ADD, S_W11,  S_BRX, D_NONE};
      5'd9:  r = '{1'b1, ACC_ADD, S_W01,  S_BLX, D_POSX};
      5'd10: r = '{1'b1, ACC_LD,  S_W00,  S_TLY, D_NONE};
      5'd11: r = '{1'b1, ACC_ADD, S_W10,  S_TRY, D_NONE};
      5'd12: r = '{1'b1, ACC_ADD, S_W11,  S_BRY, D_NONE};
      5'd13: r = '{1'b1, ACC_ADD, S_W01,  S_BLY, D_POSY};
      5'd14: r = '{1'b1, ACC_LD,  S_OMV,  S_DXT, D_NONE};
      5'd15: r = '{1'b1, ACC_ADD, S_V,    S_DXB, D_DXU};
      5'd16: r = '{1'b1, ACC_LD,  S_OMU,  S_DXL, D_NONE};
      5'd17: r = '{1'b1, ACC_ADD, S_U,    S_DXR, D_DXV};
      5'd18: r = '{1'b1, ACC_LD,  S_OMV,  S_DYT, D_NONE};
      5'd19: r = '{1'b1, ACC_ADD, S_V,    S_DYB, D_DYU};
      5'd20: r = '{1'b1, ACC_LD,  S_OMU,  S_DYL, D_NONE};
      5'd21: r = '{1'b1, ACC_ADD, S_U,    S_DYR, D_DYV};
      5'd22: r = '{1'b1, ACC_LD,  S_DXU,  S_DYV, D_NONE};
      5'd23: r = '{1'b1, ACC_SUB, S_DXV,  S_DYU, D_DET};
      5'd24: r = '{1'b0, ACC_LD,  S_POSX, S_PX,  D_EX};
      5'd25: r = '{1'b0, ACC_LD,  S_POSY, S_PY,  D_EY};
      5'd26: r = '{1'b1, ACC_LD,  S_DYV,  S_EX,  D_NONE};
      5'd27: r = '{1'b1, ACC_SUB, S_DXV,  S_EY,  D_NU};
      5'd28: r = '{1'b1, ACC_LD,  S_DXU,  S_EY,  D_NONE};
      5'd29: r = '{1'b1, ACC_SUB, S_DYU,  S_EX,  D_NV};
      5'd30: r = '{1'b0, ACC_LD,  S_U,    S_DU,  D_U};
      5'd31: r = '{1'b0, ACC_LD,  S_V,    S_DV,  D_V};
      default: r = '{1'b0, ACC_LD, S_ONE, S_ONE, D_NONE};
    endcase
    return r;
  endfunction

  function automatic logic signed [Q_W-1:0] sat32_f(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7fffffff);
    lo = -ACC_W'(64'sh80000000);
    if (a > hi) return 32'sh7fffffff;
    if (a < lo) return 32'sh80000000;
    return a[Q_W-1:0];
  endfunction

  function automatic logic [12:0] to_q112_f(input logic signed [Q_W-1:0] q);
    logic [Q_W-1:0] t;
    if (q < 0) return 13'd0;
    if (q > Q_ONE) return 13'd4096;
    t = q + 32'd2048;
    return t[24:12];
  endfunction

  function automatic logic [12:0] clamp_raw_f(input logic signed [15:0] x);
    if (x < 0) return 13'd0;
    if (x > 16'sd4096) return 13'd4096;
    return x[12:0];
  endfunction

endpackage

>>> rtl/core/ibqm_intf.sv
`timescale 1ns / 1ps
interface ibqm_pt_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink (input valid, point_x, point_y, output ready);
endinterface

interface ibqm_res_if;
  logic        valid;
  logic        ready;
  logic [12:0] map_u;
  logic [12:0] map_v;
  modport source (output valid, map_u, map_v, input ready);
  modport sink (input valid, map_u, map_v, output ready);
endinterface

interface ibqm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/inverse_bilinear_quad_map_core.sv
// Sequence: uncalibrated, the clamped point goes straight to the result register.
//   Calibrated, each Newton iteration runs 32 multiply/subtract ops (a product phase,
//   then an accumulate phase), a determinant check, two divides and a convergence check,
//   for up to MAX_ITERATIONS iterations (a zero determinant ends early); the result
//   register is then loaded. Flow: one point in flight; a new point is taken only when
//   the sequencer is idle and the previous result has left the output register.
// Reset: asynchronous active low; corners and enable clear to 0, sequencer idles.
`timescale 1ns / 1ps
`include "inverse_bilinear_quad_map_core_assert.svh"
module inverse_bilinear_quad_map_core
  import ibqm_pkg::*;
#(
  parameter int MAX_ITERATIONS = 12
) (
  input logic        clk_i,
  input logic        rst_ni,
  ibqm_cfg_if.sink   cfg_i,
  ibqm_pt_if.sink    pt_i,
  ibqm_res_if.source res_o
);

  localparam int IT_W = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(MAX_ITERATIONS - 1);

  state_e state_q, state_d;
  logic [4:0]      pc_q, pc_d;
  logic            ph_q, ph_d;
  logic [IT_W-1:0] it_q, it_d;
  logic            div_start;
  logic            div_done;
  logic signed [Q_W-1:0] div_quo;
  logic signed [Q_W-1:0] div_num;

  logic [31:0] c_tl_q, c_tr_q, c_br_q, c_bl_q;
  logic        cal_q;

  logic signed [Q_W-1:0] u_q, v_q, omu_q, omv_q, w00_q, w10_q, w11_q, w01_q;
  logic signed [Q_W-1:0] posx_q, posy_q, dxu_q, dxv_q, dyu_q, dyv_q;
  logic signed [Q_W-1:0] ex_q, ey_q, nu_q, nv_q, du_q, dv_q, px_q, py_q;
  logic signed [Q_W-1:0] dxt_q, dxb_q, dxl_q, dxr_q, dyt_q, dyb_q, dyl_q, dyr_q;
  logic signed [ACC_W-1:0] det_q, acc_q, acc_d, term;
  logic signed [63:0]      prod_q;
  logic signed [Q_W:0]     dif;
  logic signed [Q_W-1:0]   a_val, b_val, st_val;

  logic [12:0] map_u_q, map_v_q;
  logic        out_valid_q;
  logic        in_xfer;
  logic        converged;
  uop_t        uop;

  function automatic logic signed [Q_W-1:0] cx_f(input logic [15:0] c);
    return $signed({{4{c[15]}}, c, 12'd0});
  endfunction

  assign in_xfer = pt_i.valid && pt_i.ready;
  assign pt_i.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_valid_q;
  assign res_o.map_u = map_u_q;
  assign res_o.map_v = map_v_q;
  assign uop = uop_f(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_tl_q <= '0;
      c_tr_q <= '0;
      c_br_q <= '0;
      c_bl_q <= '0;
      cal_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_TL:  c_tl_q <= cfg_i.data;
        CFG_TR:  c_tr_q <= cfg_i.data;
        CFG_BR:  c_br_q <= cfg_i.data;
        CFG_BL:  c_bl_q <= cfg_i.data;
        CFG_CAL: cal_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [Q_W-1:0] rd_f(input src_e s);
    case (s)
      S_ONE:  return Q_ONE;
      S_U:    return u_q;
      S_V:    return v_q;
      S_OMU:  return omu_q;
      S_OMV:  return omv_q;
      S_W00:  return w00_q;
      S_W10:  return w10_q;
      S_W11:  return w11_q;
      S_W01:  return w01_q;
      S_TLX:  return cx_f(c_tl_q[15:0]);
      S_TRX:  return cx_f(c_tr_q[15:0]);
      S_BRX:  return cx_f(c_br_q[15:0]);
      S_BLX:  return cx_f(c_bl_q[15:0]);
      S_TLY:  return cx_f(c_tl_q[31:16]);
      S_TRY:  return cx_f(c_tr_q[31:16]);
      S_BRY:  return cx_f(c_br_q[31:16]);
      S_BLY:  return cx_f(c_bl_q[31:16]);
      S_DXT:  return dxt_q;
      S_DXB:  return dxb_q;
      S_DXL:  return dxl_q;
      S_DXR:  return dxr_q;
      S_DYT:  return dyt_q;
      S_DYB:  return dyb_q;
      S_DYL:  return dyl_q;
      S_DYR:  return dyr_q;
      S_POSX: return posx_q;
      S_POSY: return posy_q;
      S_PX:   return px_q;
      S_PY:   return py_q;
      S_DXU:  return dxu_q;
      S_DXV:  return dxv_q;
      S_DYU:  return dyu_q;
      S_DYV:  return dyv_q;
      S_EX:   return ex_q;
      S_EY:   return ey_q;
      S_DU:   return du_q;
      S_DV:   return dv_q;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    a_val = rd_f(uop.a);
    b_val = rd_f(uop.b);
    dif   = {a_val[Q_W-1], a_val} - {b_val[Q_W-1], b_val};
    term  = uop.mul ? ACC_W'(prod_q >>> FRAC) : ACC_W'(prod_q);
    case (uop.mode)
      ACC_LD:  acc_d = term;
      ACC_ADD: acc_d = acc_q + term;
      ACC_SUB: acc_d = acc_q - term;
      default: acc_d = term;
    endcase
    st_val    = sat32_f(acc_d);
    converged = (du_q > -STEP_THR) && (du_q < STEP_THR) &&
                (dv_q > -STEP_THR) && (dv_q < STEP_THR);
    div_num   = (state_q == ST_RUN) ? nu_q : nv_q;
  end

  // Shared datapath: phase 0 forms the product or difference, phase 1 accumulates.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q  <= cx_f(pt_i.point_x);
      py_q  <= cx_f(pt_i.point_y);
      u_q   <= Q_HALF;
      v_q   <= Q_HALF;
      dxt_q <= cx_f(c_tr_q[15:0]) - cx_f(c_tl_q[15:0]);
      dxb_q <= cx_f(c_br_q[15:0]) - cx_f(c_bl_q[15:0]);
      dxl_q <= cx_f(c_bl_q[15:0]) - cx_f(c_tl_q[15:0]);
      dxr_q <= cx_f(c_br_q[15:0]) - cx_f(c_tr_q[15:0]);
      dyt_q <= cx_f(c_tr_q[31:16]) - cx_f(c_tl_q[31:16]);
      dyb_q <= cx_f(c_br_q[31:16]) - cx_f(c_bl_q[31:16]);
      dyl_q <= cx_f(c_bl_q[31:16]) - cx_f(c_tl_q[31:16]);
      dyr_q <= cx_f(c_br_q[31:16]) - cx_f(c_tr_q[31:16]);
    end
    if (state_q == ST_RUN && !ph_q) begin
      prod_q <= uop.mul ? (a_val * b_val) : 64'(dif);
    end
    if (state_q == ST_RUN && ph_q) begin
      acc_q <= acc_d;
      case (uop.d)
        D_U:    u_q    <= st_val;
        D_V:    v_q    <= st_val;
        D_OMU:  omu_q  <= st_val;
        D_OMV:  omv_q  <= st_val;
        D_W00:  w00_q  <= st_val;
        D_W10:  w10_q  <= st_val;
        D_W11:  w11_q  <= st_val;
        D_W01:  w01_q  <= st_val;
        D_POSX: posx_q <= st_val;
        D_POSY: posy_q <= st_val;
        D_DXU:  dxu_q  <= st_val;
        D_DXV:  dxv_q  <= st_val;
        D_DYU:  dyu_q  <= st_val;
        D_DYV:  dyv_q  <= st_val;
        D_DET:  det_q  <= acc_d;
        D_EX:   ex_q   <= st_val;
        D_EY:   ey_q   <= st_val;
        D_NU:   nu_q   <= st_val;
        D_NV:   nv_q   <= st_val;
        default: ;
      endcase
    end
    if (state_q == ST_DIVU && div_done) begin
      du_q <= div_quo;
    end
    if (state_q == ST_DIVV && div_done) begin
      dv_q <= div_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      ph_q    <= 1'b0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      ph_q    <= ph_d;
      it_q    <= it_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    ph_d      = ph_q;
    it_d      = it_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && cal_q) begin
          state_d = ST_RUN;
          pc_d    = '0;
          ph_d    = 1'b0;
          it_d    = '0;
        end
      end
      ST_RUN: begin
        ph_d = !ph_q;
        if (ph_q) begin
          if (pc_q == PC_DET) begin
            state_d = ST_DETCHK;
          end else if (pc_q == PC_NUM) begin
            state_d   = ST_DIVU;
            div_start = 1'b1;
          end else if (pc_q == PC_LAST) begin
            state_d = ST_CONV;
          end else begin
            pc_d = pc_q + 5'd1;
          end
        end
      end
      ST_DETCHK: begin
        if (det_q == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RUN;
          pc_d    = PC_ERR;
        end
      end
      ST_DIVU: begin
        if (div_done) begin
          state_d   = ST_DIVV;
          div_start = 1'b1;
        end
      end
      ST_DIVV: begin
        if (div_done) begin
          state_d = ST_RUN;
          pc_d    = PC_UPD;
        end
      end
      ST_CONV: begin
        if (converged || it_q == IT_LAST) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RUN;
          pc_d    = '0;
          it_d    = it_q + IT_W'(1);
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_xfer && !cal_q) || state_q == ST_DONE) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && !cal_q) begin
      map_u_q <= clamp_raw_f(pt_i.point_x);
      map_v_q <= clamp_raw_f(pt_i.point_y);
    end else if (state_q == ST_DONE) begin
      map_u_q <= to_q112_f(u_q);
      map_v_q <= to_q112_f(v_q);
    end
  end

  ibqm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (det_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  `IBQM_ASSERT_NOW(a_busy_not_ready, state_q != ST_IDLE, !pt_i.ready)
  `IBQM_ASSERT_NEXT(a_det_zero_stops, state_q == ST_DETCHK && det_q == '0,
                    state_q == ST_DONE)
  `IBQM_ASSERT_NOW(a_res_range, res_o.valid,
                   res_o.map_u <= 13'd4096 && res_o.map_v <= 13'd4096)
  `IBQM_ASSERT_NOW(a_div_done_ctx, div_done, state_q == ST_DIVU || state_q == ST_DIVV)

endmodule

>>> rtl/core/ibqm_div.sv
`timescale 1ns / 1ps
module ibqm_div
  import ibqm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [Q_W-1:0]   num_i,
  input  logic signed [ACC_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [Q_W-1:0]   quo_o
);

  // (num * 2^24) / den, truncated toward zero, saturated to 32 bits.
  logic [Q_W-1:0]   num_mag;
  logic [ACC_W-1:0] den_mag;
  logic [ACC_W-1:0] den_q;
  logic [ACC_W-1:0] rem_q;
  logic [Q_W-1:0]   low_q;
  logic [Q_W-1:0]   quo_q;
  logic [5:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             neg_q;
  logic             ovf_q;
  logic [ACC_W:0]   trial;
  logic [ACC_W:0]   diff;

  assign num_mag = num_i[Q_W-1] ? Q_W'(-num_i) : Q_W'(num_i);
  assign den_mag = den_i[ACC_W-1] ? ACC_W'(-den_i) : ACC_W'(den_i);
  assign trial   = {rem_q, low_q[Q_W-1]};
  assign diff    = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_mag;
      rem_q <= ACC_W'(num_mag[Q_W-1:8]);
      low_q <= {num_mag[7:0], 24'd0};
      quo_q <= '0;
      neg_q <= num_i[Q_W-1] ^ den_i[ACC_W-1];
      ovf_q <= ACC_W'(num_mag[Q_W-1:8]) >= den_mag;
    end else if (busy_q) begin
      low_q <= {low_q[Q_W-2:0], 1'b0};
      if (!diff[ACC_W]) begin
        rem_q <= diff[ACC_W-1:0];
        quo_q <= {quo_q[Q_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[ACC_W-1:0];
        quo_q <= {quo_q[Q_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (ovf_q) begin
      quo_o = neg_q ? 32'sh80000000 : 32'sh7fffffff;
    end else if (!neg_q) begin
      quo_o = quo_q[Q_W-1] ? 32'sh7fffffff : $signed(quo_q);
    end else begin
      quo_o = (quo_q > 32'h80000000) ? 32'sh80000000 : $signed(-quo_q);
    end
  end

  assign done_o = done_q;

endmodule

>>> tb/sv/ibqm_checker.sv
`timescale 1ns / 1ps
module ibqm_checker
  import ibqm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ibqm_cfg_if  cfg,
  ibqm_pt_if   pt,
  ibqm_res_if  res,
  output int   fail_count,
  output int   pending_count,
  output int   result_count
);

  typedef struct packed {
    logic [12:0] u;
    logic [12:0] v;
  } uv_t;

  logic [31:0] corner_tl, corner_tr, corner_br, corner_bl;
  logic        cal_en;
  uv_t         expected_uv[$];

  function automatic longint sat32(input longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 24;
  endfunction

  function automatic longint cx(input logic [31:0] c);
    return longint'($signed(c[15:0])) * 4096;
  endfunction

  function automatic longint cy(input logic [31:0] c);
    return longint'($signed(c[31:16])) * 4096;
  endfunction

  function automatic logic [12:0] unit_q112(input longint q);
    longint t;
    t = q < 0 ? 0 : (q > 64'sd16777216 ? 64'sd16777216 : q);
    t = (t + 2048) >>> 12;
    return t[12:0];
  endfunction

  function automatic logic [12:0] clamp_point(input logic signed [15:0] x);
    longint t;
    t = x;
    if (t < 0) t = 0;
    if (t > 4096) t = 4096;
    return t[12:0];
  endfunction

  function automatic uv_t map_point(input logic signed [15:0] x, input logic signed [15:0] y);
    uv_t r;
    longint tlx, tly, trx, try_, brx, bry, blx, bly, px, py, u, v;
    longint omu, omv, w00, w10, w11, w01, posx, posy, dxu, dxv, dyu, dyv, det;
    longint ex, ey, nu, nv, du, dv;
    if (!cal_en) begin
      r.u = clamp_point(x);
      r.v = clamp_point(y);
      return r;
    end
    tlx = cx(corner_tl); tly = cy(corner_tl);
    trx = cx(corner_tr); try_ = cy(corner_tr);
    brx = cx(corner_br); bry = cy(corner_br);
    blx = cx(corner_bl); bly = cy(corner_bl);
    px = longint'(x) * 4096;
    py = longint'(y) * 4096;
    u = 64'sd8388608;
    v = 64'sd8388608;
    for (int it = 0; it < 12; it++) begin
      omu = sat32(64'sd16777216 - u);
      omv = sat32(64'sd16777216 - v);
      w00 = sat32(qmul(omu, omv));
      w10 = sat32(qmul(u, omv));
      w11 = sat32(qmul(u, v));
      w01 = sat32(qmul(omu, v));
      posx = sat32(qmul(w00, tlx) + qmul(w10, trx) + qmul(w11, brx) + qmul(w01, blx));
      posy = sat32(qmul(w00, tly) + qmul(w10, try_) + qmul(w11, bry) + qmul(w01, bly));
      dxu = sat32(qmul(omv, trx - tlx) + qmul(v, brx - blx));
      dxv = sat32(qmul(omu, blx - tlx) + qmul(u, brx - trx));
      dyu = sat32(qmul(omv, try_ - tly) + qmul(v, bry - bly));
      dyv = sat32(qmul(omu, bly - tly) + qmul(u, bry - try_));
      det = qmul(dxu, dyv) - qmul(dxv, dyu);
      if (det == 0) break;
      ex = sat32(posx - px);
      ey = sat32(posy - py);
      nu = sat32(qmul(dyv, ex) - qmul(dxv, ey));
      nv = sat32(qmul(dxu, ey) - qmul(dyu, ex));
      du = sat32((nu * 64'sd16777216) / det);
      dv = sat32((nv * 64'sd16777216) / det);
      u = sat32(u - du);
      v = sat32(v - dv);
      if (du > -168 && du < 168 && dv > -168 && dv < 168) break;
    end
    r.u = unit_q112(u);
    r.v = unit_q112(v);
    return r;
  endfunction

  assign pending_count = expected_uv.size();

  always @(posedge clk_i or negedge rst_ni) begin
    uv_t e;
    if (!rst_ni) begin
      corner_tl <= '0;
      corner_tr <= '0;
      corner_br <= '0;
      corner_bl <= '0;
      cal_en <= 1'b0;
      fail_count <= 0;
      result_count <= 0;
      expected_uv.delete();
    end else begin
      if (pt.valid && pt.ready) expected_uv.push_back(map_point(pt.point_x, pt.point_y));
      if (res.valid && res.ready) begin
        result_count <= result_count + 1;
        if (expected_uv.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result u=%0d v=%0d", res.map_u, res.map_v);
        end else begin
          e = expected_uv.pop_front();
          if (e.u !== res.map_u || e.v !== res.map_v) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected u=%0d v=%0d, got u=%0d v=%0d",
                       e.u, e.v, res.map_u, res.map_v);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_TL:  corner_tl <= cfg.data;
          CFG_TR:  corner_tr <= cfg.data;
          CFG_BR:  corner_br <= cfg.data;
          CFG_BL:  corner_bl <= cfg.data;
          CFG_CAL: cal_en <= cfg.data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ibqm_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending_count, result_count;
  int   points_sent;
  int   corner_sets;
  bit   rx_quiet;
  bit   rx_long_hold;

  ibqm_cfg_if cfg ();
  ibqm_pt_if  pt ();
  ibqm_res_if res ();

  inverse_bilinear_quad_map_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .pt_i  (pt),
    .res_o (res)
  );

  ibqm_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg          (cfg),
    .pt           (pt),
    .res          (res),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .result_count (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #300ms;
    $display("inverse_bilinear_quad_map_core test failed");
    $finish;
  end

  // result side: random stalls, with one long hold on request
  initial begin
    int w;
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_long_hold) begin
        res.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        rx_long_hold = 1'b0;
      end
      w = rx_quiet ? 0 : $urandom_range(0, 7);
      if (w > 0) begin
        res.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      @(posedge clk_i);
      while (!res.valid) @(posedge clk_i);
    end
  end

  task automatic drain();
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_quad(input int tlx, tly, trx, try_, brx, bry, blx, bly);
    write_reg(CFG_TL, {tly[15:0], tlx[15:0]});
    write_reg(CFG_TR, {try_[15:0], trx[15:0]});
    write_reg(CFG_BR, {bry[15:0], brx[15:0]});
    write_reg(CFG_BL, {bly[15:0], blx[15:0]});
    corner_sets++;
  endtask

  task automatic send_point(input logic [15:0] x, input logic [15:0] y, input bit quiet);
    int w;
    w = quiet ? 0 : $urandom_range(0, 7);
    if (w > 0) begin
      pt.valid <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    pt.valid   <= 1'b1;
    pt.point_x <= x;
    pt.point_y <= y;
    @(posedge clk_i);
    while (!pt.ready) @(posedge clk_i);
    points_sent++;
  endtask

  task automatic stop_points();
    pt.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random point: mostly inside or near the quad, the rest anywhere
  task automatic random_points(input int n, input int q[8]);
    int a, b, x, y;
    bit quiet;
    for (int i = 0; i < n; i++) begin
      quiet = (i / 40) % 3 == 2;
      rx_quiet = quiet;
      if ($urandom_range(0, 3) != 0) begin
        a = $urandom_range(0, 80) - 20;
        b = $urandom_range(0, 80) - 20;
        x = ((q[0] * (40 - a) + q[2] * a) * (40 - b) + (q[6] * (40 - a) + q[4] * a) * b) / 1600;
        y = ((q[1] * (40 - a) + q[3] * a) * (40 - b) + (q[7] * (40 - a) + q[5] * a) * b) / 1600;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        send_point(x[15:0], y[15:0], quiet);
      end else begin
        send_point(16'($urandom()), 16'($urandom()), quiet);
      end
    end
    rx_quiet = 1'b0;
  endtask

  task automatic quad_phase(input int q[8], input int n);
    set_quad(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]);
    random_points(n, q);
    stop_points();
    drain();
  endtask

  initial begin
    int q[8];
    logic [15:0] edge_vals[6];
    edge_vals = '{16'h0000, 16'h7fff, 16'h8000, 16'h1000, 16'hffff, 16'h0800};
    rst_ni = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    pt.valid = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    rx_quiet = 1'b0;
    rx_long_hold = 1'b0;
    points_sent = 0;
    corner_sets = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through from reset, then after an explicit disable
    foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[5 - i], 1'b0);
    send_point(16'h1001, 16'h0fff, 1'b0);
    stop_points();
    drain();
    write_reg(CFG_CAL, 32'd0);
    for (int i = 0; i < 120; i++) send_point(16'($urandom()), 16'($urandom()), bit'(i % 2));
    stop_points();
    drain();

    // unit square, calibrated
    q = '{0, 0, 4096, 0, 4096, 4096, 0, 4096};
    set_quad(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]);
    write_reg(CFG_CAL, 32'hffff_fffd);
    foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[(i + 2) % 6], 1'b0);
    send_point(16'h0800, 16'h0800, 1'b0);
    send_point(16'h1000, 16'h1000, 1'b0);
    send_point(16'h0000, 16'h1000, 1'b0);
    random_points(200, q);
    // sender waits for the block to empty mid-phase
    stop_points();
    drain();
    // receiver holds off while points keep coming
    rx_long_hold = 1'b1;
    random_points(100, q);
    stop_points();
    drain();

    // perturbed quads, some concave or twisted
    for (int k = 0; k < 7; k++) begin
      q[0] = -$urandom_range(1000, 12000); q[1] = -$urandom_range(1000, 12000);
      q[2] = $urandom_range(1000, 12000);  q[3] = -$urandom_range(1000, 12000);
      q[4] = $urandom_range(1000, 12000);  q[5] = $urandom_range(1000, 12000);
      q[6] = -$urandom_range(1000, 12000); q[7] = $urandom_range(1000, 12000);
      if (k == 5) begin
        q[4] = q[0] / 2; q[5] = q[1] / 2;
      end
      if (k == 6) begin
        q[2] = q[4]; q[3] = q[5] + 3000;
      end
      quad_phase(q, 140);
    end

    // extreme corners, saturating arithmetic
    q = '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767};
    quad_phase(q, 60);
    q = '{32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768};
    quad_phase(q, 40);
    q = '{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768};
    quad_phase(q, 40);

    // zero determinant: all corners equal, then collinear
    q = '{1234, -777, 1234, -777, 1234, -777, 1234, -777};
    quad_phase(q, 40);
    q = '{0, 0, 4096, 4096, 8192, 8192, 2048, 2048};
    quad_phase(q, 40);
    q = '{0, 0, 0, 0, 0, 0, 0, 0};
    quad_phase(q, 20);

    // back to pass-through
    write_reg(CFG_CAL, 32'd0);
    for (int i = 0; i < 100; i++) send_point(16'($urandom()), 16'($urandom()), 1'b0);
    stop_points();
    drain();
    repeat (50) @(posedge clk_i);

    $display("covered %0d points, %0d results, %0d corner settings, both modes",
             points_sent, result_count, corner_sets);
    if (fail_count == 0 && pending_count == 0) begin
      $display("inverse_bilinear_quad_map_core test passed");
    end else begin
      $display("inverse_bilinear_quad_map_core test failed");
    end
    $finish;
  end

endmodule
